// ===== rtl/bebd_pkg.sv =====
// bebd_pkg: widths, reset values, register indexes and word types of the
// block energy beep detector. No dependencies.
package bebd_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int SAMPLE_BITS = 16;
   localparam int LEN_W       = 16;
   localparam int ENERGY_W    = 47;
   localparam int FRAME_W     = 8;
   localparam int OFFSET_W    = 32;
   localparam int SQ_W        = 2 * SAMPLE_BITS;
   localparam int SUM_W       = ((SQ_W > ENERGY_W) ? SQ_W : ENERGY_W) + 1;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = ENERGY_W;

   localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

   localparam logic [LEN_W-1:0]    BLOCK_LENGTH_RESET     = 16'd4410;
   localparam logic [ENERGY_W-1:0] ENERGY_THRESHOLD_RESET = 47'd7575859890;
   localparam logic [FRAME_W-1:0]  FRAME_BYTES_RESET      = 8'd2;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_BLOCK_LENGTH     = 2'd0;
   localparam csr_index_type CSR_ENERGY_THRESHOLD = 2'd1;
   localparam csr_index_type CSR_FRAME_BYTES      = 2'd2;

   typedef struct packed {
      logic [LEN_W-1:0]    block_length;
      logic [ENERGY_W-1:0] energy_threshold;
      logic [FRAME_W-1:0]  frame_bytes;
   } cfg_type;

   typedef struct packed {
      logic [SQ_W-1:0] square;
      logic            last;
   } sq_word_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] begin_sample;
      logic [OFFSET_W-1:0] end_sample;
   } mark_type;

endpackage

// ===== rtl/bebd_if.sv =====
// bebd_if: valid/ready channel interfaces for samples, markers and register
// writes. Depends on bebd_pkg.
interface bebd_req_if;
   import bebd_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       last;
   modport source (output valid, output sample, output last, input ready);
   modport sink (input valid, input sample, input last, output ready);
endinterface

interface bebd_rsp_if;
   import bebd_pkg::*;
   logic                valid;
   logic                ready;
   logic [OFFSET_W-1:0] begin_offset;
   logic [OFFSET_W-1:0] end_offset;
   modport source (output valid, output begin_offset, output end_offset, input ready);
   modport sink (input valid, input begin_offset, input end_offset, output ready);
endinterface

interface bebd_csr_if;
   import bebd_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/bebd_csr.sv =====
// bebd_csr: configuration registers written over the csr channel.
// Depends on bebd_pkg and bebd_if.
module bebd_csr (
   input  logic              clock,
   input  logic              reset,
   bebd_csr_if.sink          csr,
   output bebd_pkg::cfg_type cfg
);
   import bebd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr.index)
            CSR_BLOCK_LENGTH:     cfg_in.block_length     = csr.data[LEN_W-1:0];
            CSR_ENERGY_THRESHOLD: cfg_in.energy_threshold = csr.data[ENERGY_W-1:0];
            CSR_FRAME_BYTES:      cfg_in.frame_bytes      = csr.data[FRAME_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.block_length     <= BLOCK_LENGTH_RESET;
         cfg_ff.energy_threshold <= ENERGY_THRESHOLD_RESET;
         cfg_ff.frame_bytes      <= FRAME_BYTES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/bebd_square.sv =====
// bebd_square: input register and squaring stage for incoming samples.
// Depends on bebd_pkg and bebd_if.
module bebd_square (
   input  logic                  clock,
   input  logic                  reset,
   bebd_req_if.sink              req,
   output logic                  sq_valid,
   output bebd_pkg::sq_word_type sq_word,
   input  logic                  sq_ready
);
   import bebd_pkg::*;

   logic                          in_valid_ff;
   logic                          in_valid_in;
   logic signed [SAMPLE_BITS-1:0] in_sample_ff;
   logic                          in_last_ff;
   logic                          in_ready;
   logic                          sq_valid_ff;
   logic                          sq_valid_in;
   sq_word_type                   sq_word_ff;
   logic signed [SQ_W-1:0]        product;

   assign in_ready  = !sq_valid_ff || sq_ready;
   assign req.ready = !in_valid_ff || in_ready;
   assign sq_valid  = sq_valid_ff;
   assign sq_word   = sq_word_ff;
   assign product   = in_sample_ff * in_sample_ff;

   always_comb begin
      in_valid_in = req.ready ? req.valid : in_valid_ff;
      sq_valid_in = in_ready ? in_valid_ff : sq_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         sq_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         sq_valid_ff <= sq_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_sample_ff <= req.sample[SAMPLE_BITS-1:0];
         in_last_ff   <= req.last;
      end
      if (in_valid_ff && in_ready) begin
         sq_word_ff.square <= SQ_W'($unsigned(product));
         sq_word_ff.last   <= in_last_ff;
      end
   end

endmodule

// ===== rtl/bebd_tracker.sv =====
// bebd_tracker: block energy accumulation, on/off detection and marker
// register. Depends on bebd_pkg.
module bebd_tracker (
   input  logic                  clock,
   input  logic                  reset,
   input  bebd_pkg::cfg_type     cfg,
   input  logic                  sq_valid,
   input  bebd_pkg::sq_word_type sq_word,
   output logic                  sq_ready,
   output logic                  mark_valid,
   output bebd_pkg::mark_type    mark,
   input  logic                  mark_ready
);
   import bebd_pkg::*;

   logic                active_ff;
   logic                active_in;
   logic [ENERGY_W-1:0] energy_ff;
   logic [ENERGY_W-1:0] energy_in;
   logic [LEN_W-1:0]    pos_ff;
   logic [LEN_W-1:0]    pos_in;
   logic [OFFSET_W-1:0] block_start_ff;
   logic [OFFSET_W-1:0] block_start_in;
   logic [OFFSET_W-1:0] beep_start_ff;
   logic [OFFSET_W-1:0] beep_start_in;
   logic                mark_valid_ff;
   logic                mark_valid_in;
   mark_type            mark_ff;
   mark_type            mark_in;

   logic                consume;
   logic                emit;
   logic [LEN_W:0]      eff_len;
   logic [LEN_W:0]      taken;
   logic [SUM_W-1:0]    sum;
   logic [ENERGY_W-1:0] sat;
   logic                close;
   logic                turn_on;
   logic                turn_off;
   logic                active_v;
   logic [OFFSET_W-1:0] beep_start_v;

   assign sq_ready   = !mark_valid_ff || mark_ready;
   assign consume    = sq_valid && sq_ready;
   assign mark_valid = mark_valid_ff;
   assign mark       = mark_ff;

   always_comb begin
      eff_len = (cfg.block_length == '0) ? {1'b1, LEN_W'(0)} : {1'b0, cfg.block_length};
      sum     = SUM_W'(energy_ff) + SUM_W'(sq_word.square);
      sat     = (sum > SUM_W'(ENERGY_MAX)) ? ENERGY_MAX : sum[ENERGY_W-1:0];
      taken   = {1'b0, pos_ff} + (LEN_W+1)'(1);
      close   = (taken >= eff_len) || sq_word.last;
      turn_off     = active_ff && (sat < cfg.energy_threshold);
      turn_on      = !active_ff && (sat > cfg.energy_threshold);
      active_v     = turn_on ? 1'b1 : (turn_off ? 1'b0 : active_ff);
      beep_start_v = turn_on ? block_start_ff : beep_start_ff;
   end

   always_comb begin
      active_in      = active_ff;
      energy_in      = energy_ff;
      pos_in         = pos_ff;
      block_start_in = block_start_ff;
      beep_start_in  = beep_start_ff;
      emit           = 1'b0;
      mark_in        = mark_ff;
      if (consume) begin
         if (!close) begin
            energy_in = sat;
            pos_in    = taken[LEN_W-1:0];
         end else begin
            if (turn_off) begin
               emit                 = 1'b1;
               mark_in.begin_sample = beep_start_ff;
               mark_in.end_sample   = block_start_ff;
            end
            if (sq_word.last) begin
               if (active_v) begin
                  emit                 = 1'b1;
                  mark_in.begin_sample = beep_start_v;
                  mark_in.end_sample   = block_start_ff + OFFSET_W'(eff_len);
               end
               active_in      = 1'b0;
               energy_in      = '0;
               pos_in         = '0;
               block_start_in = '0;
               beep_start_in  = '0;
            end else begin
               active_in      = active_v;
               beep_start_in  = beep_start_v;
               energy_in      = '0;
               pos_in         = '0;
               block_start_in = block_start_ff + OFFSET_W'(taken);
            end
         end
      end
      mark_valid_in = sq_ready ? emit : mark_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= 1'b0;
         energy_ff      <= '0;
         pos_ff         <= '0;
         block_start_ff <= '0;
         beep_start_ff  <= '0;
         mark_valid_ff  <= 1'b0;
      end else begin
         active_ff      <= active_in;
         energy_ff      <= energy_in;
         pos_ff         <= pos_in;
         block_start_ff <= block_start_in;
         beep_start_ff  <= beep_start_in;
         mark_valid_ff  <= mark_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mark_ff <= mark_in;
   end

endmodule

// ===== rtl/bebd_scale.sv =====
// bebd_scale: scales marker sample indices to byte offsets and holds the
// result word. Depends on bebd_pkg and bebd_if.
module bebd_scale (
   input  logic               clock,
   input  logic               reset,
   input  bebd_pkg::cfg_type  cfg,
   input  logic               mark_valid,
   input  bebd_pkg::mark_type mark,
   output logic               mark_ready,
   bebd_rsp_if.source         rsp
);
   import bebd_pkg::*;

   localparam int PROD_W = OFFSET_W + FRAME_W;

   logic                out_valid_ff;
   logic                out_valid_in;
   logic [OFFSET_W-1:0] begin_ff;
   logic [OFFSET_W-1:0] end_ff;
   logic [PROD_W-1:0]   begin_prod;
   logic [PROD_W-1:0]   end_prod;

   assign mark_ready       = !out_valid_ff || rsp.ready;
   assign rsp.valid        = out_valid_ff;
   assign rsp.begin_offset = begin_ff;
   assign rsp.end_offset   = end_ff;
   assign begin_prod       = PROD_W'(mark.begin_sample) * PROD_W'(cfg.frame_bytes);
   assign end_prod         = PROD_W'(mark.end_sample) * PROD_W'(cfg.frame_bytes);
   assign out_valid_in     = mark_ready ? mark_valid : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mark_valid && mark_ready) begin
         begin_ff <= begin_prod[OFFSET_W-1:0];
         end_ff   <= end_prod[OFFSET_W-1:0];
      end
   end

endmodule

// ===== rtl/block_energy_beep_detector.sv =====
// path: an accepted sample passes the input, square, marker and result registers before its marker is valid
// throughput: one sample per cycle; a marker waiting on rsp does not stop intake
//   until the internal stages behind it are full
// pipeline: input register, square, energy/detect, offset scaling + result register
// reset: synchronous; empties the pipeline, clears stream state, loads register defaults
// depends on bebd_pkg, bebd_if, bebd_csr, bebd_square, bebd_tracker, bebd_scale
module block_energy_beep_detector (
   input logic        clock,
   input logic        reset,
   bebd_req_if.sink   req,
   bebd_rsp_if.source rsp,
   bebd_csr_if.sink   csr
);
   import bebd_pkg::*;

   cfg_type     cfg;
   logic        sq_valid;
   sq_word_type sq_word;
   logic        sq_ready;
   logic        mark_valid;
   mark_type    mark;
   logic        mark_ready;

   bebd_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .cfg   (cfg)
   );

   bebd_square u_square (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .sq_valid (sq_valid),
      .sq_word  (sq_word),
      .sq_ready (sq_ready)
   );

   bebd_tracker u_tracker (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .sq_valid   (sq_valid),
      .sq_word    (sq_word),
      .sq_ready   (sq_ready),
      .mark_valid (mark_valid),
      .mark       (mark),
      .mark_ready (mark_ready)
   );

   bebd_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .mark_valid (mark_valid),
      .mark       (mark),
      .mark_ready (mark_ready),
      .rsp        (rsp)
   );

endmodule

// ===== rtl/bebd_checker.sv =====
// bebd_checker: port-level assertions for the beep detector, bound to the
// top level. Depends on bebd_pkg and block_energy_beep_detector.
module bebd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [bebd_pkg::OFFSET_W-1:0] rsp_begin_offset,
   input logic [bebd_pkg::OFFSET_W-1:0] rsp_end_offset
);
   import bebd_pkg::*;

   logic req_accept;
   logic drain;

   assign req_accept = req_valid && req_ready;
   assign drain      = !req_accept && rsp_ready;

   // result register empties on reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // with no result pending the whole pipeline can move
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("sample intake stalled with empty result register");

   // free cycles without intake, one for each register stage, drain every stage
   assert property (@(posedge clock) disable iff (reset)
      ($past(drain, 1) && $past(drain, 2) && $past(drain, 3) && $past(drain, 4))
      |-> !rsp_valid)
      else $error("marker appeared without a sample behind it");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_begin_offset) && $stable(rsp_end_offset)))
      else $error("stalled marker changed");

endmodule

bind block_energy_beep_detector bebd_checker u_bebd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_begin_offset (rsp.begin_offset),
   .rsp_end_offset   (rsp.end_offset)
);

// ===== tb/block_energy_beep_detector_tb.sv =====
// testbench for block_energy_beep_detector: directed and random sample streams,
// scoreboard against an in-bench detector model, random idling and a long rsp stall
// depends on bebd_pkg, bebd_if and the rtl of the detector
module block_energy_beep_detector_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bebd_pkg::*;

   localparam int IDLE_MAX      = 19;
   localparam int SETTLE_CYCLES = 12;
   localparam int TAIL_CYCLES   = 20;
   localparam int STALL_LIMIT   = 3000;
   localparam int HOLD_CYCLES   = 400;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
   localparam csr_index_type CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
   } sample_word_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] begin_offset;
      logic [OFFSET_W-1:0] end_offset;
   } marker_type;

   logic clock = 1'b0;
   logic reset;

   bebd_req_if req_ch ();
   bebd_rsp_if rsp_ch ();
   bebd_csr_if csr_ch ();

   block_energy_beep_detector dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   always #1 clock = ~clock;

   sample_word_type samples_pending[$];
   marker_type      markers_due[$];
   int              mismatches = 0;

   // detector copy: registers and stream state
   logic [LEN_W-1:0]    cfg_len;
   logic [ENERGY_W-1:0] cfg_thresh;
   logic [FRAME_W-1:0]  cfg_frame;
   logic                beep_on;
   logic [ENERGY_W-1:0] energy;
   logic [LEN_W-1:0]    pos;
   logic [OFFSET_W-1:0] blk_start;
   logic [OFFSET_W-1:0] beep_start;

   // handshake bookkeeping
   bit              req_fire = 1'b0;
   bit              req_busy = 1'b0;
   int              req_gap = 0;
   bit              req_idle_on = 1'b1;
   bit              rsp_fire = 1'b0;
   bit              rsp_valid_seen = 1'b0;
   int              rsp_gap = 0;
   bit              rsp_idle_on = 1'b1;
   int              rsp_hold_left = 0;
   int              stall_count = 0;
   sample_word_type next_word;
   marker_type      want_marker;

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
   endtask

   function automatic logic [OFFSET_W-1:0] byte_offset(input logic [OFFSET_W-1:0] s);
      return s * OFFSET_W'(cfg_frame);
   endfunction

   function automatic void clear_stream();
      beep_on    = 1'b0;
      energy     = '0;
      pos        = '0;
      blk_start  = '0;
      beep_start = '0;
   endfunction

   task automatic detector_step(input logic signed [SAMPLE_W-1:0] smp, input logic is_last);
      int                  sv;
      int                  sq;
      logic [16:0]         eff_len;
      logic [16:0]         taken;
      logic [ENERGY_W:0]   acc;
      marker_type          m;
      bit                  hit;
      sv = int'(smp);
      sq = sv * sv;
      eff_len = (cfg_len == '0) ? 17'd65536 : {1'b0, cfg_len};
      acc = {1'b0, energy} + (ENERGY_W+1)'(sq);
      energy = (acc > {1'b0, ENERGY_MAX}) ? ENERGY_MAX : acc[ENERGY_W-1:0];
      taken = {1'b0, pos} + 17'd1;
      hit = 1'b0;
      if (taken < eff_len && !is_last) begin
         pos = taken[LEN_W-1:0];
      end else begin
         if (beep_on && energy < cfg_thresh) begin
            beep_on = 1'b0;
            m.begin_offset = byte_offset(beep_start);
            m.end_offset   = byte_offset(blk_start);
            hit = 1'b1;
         end else if (!beep_on && energy > cfg_thresh) begin
            beep_on    = 1'b1;
            beep_start = blk_start;
         end
         if (is_last) begin
            if (beep_on) begin
               m.begin_offset = byte_offset(beep_start);
               m.end_offset   = byte_offset(blk_start + OFFSET_W'(eff_len));
               hit = 1'b1;
            end
            clear_stream();
         end else begin
            blk_start = blk_start + OFFSET_W'(taken);
            energy    = '0;
            pos       = '0;
         end
      end
      if (hit)
         markers_due.push_back(m);
   endtask

   // sample driver
   always @(posedge clock) begin
      req_fire = !reset && req_ch.valid && req_ch.ready;
      if (req_fire)
         detector_step(req_ch.sample, req_ch.last);
   end

   always @(negedge clock) begin
      if (req_fire)
         req_busy = 1'b0;
      if (!reset && !req_busy && samples_pending.size() > 0) begin
         if (req_gap > 0) begin
            req_gap--;
         end else begin
            next_word = samples_pending.pop_front();
            req_ch.sample <= next_word.sample;
            req_ch.last   <= next_word.last;
            req_busy = 1'b1;
            req_gap  = req_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
         end
      end
      req_ch.valid <= req_busy;
   end

   // marker monitor and receiver
   always @(posedge clock) begin
      rsp_valid_seen = rsp_ch.valid;
      rsp_fire = !reset && rsp_ch.valid && rsp_ch.ready;
      if (rsp_fire) begin
         if (markers_due.size() == 0) begin
            report_mismatch($sformatf("unexpected marker begin %0d end %0d",
                                      rsp_ch.begin_offset, rsp_ch.end_offset));
         end else begin
            want_marker = markers_due.pop_front();
            if (rsp_ch.begin_offset !== want_marker.begin_offset)
               report_mismatch($sformatf("begin_offset got %0d want %0d",
                                         rsp_ch.begin_offset, want_marker.begin_offset));
            if (rsp_ch.end_offset !== want_marker.end_offset)
               report_mismatch($sformatf("end_offset got %0d want %0d",
                                         rsp_ch.end_offset, want_marker.end_offset));
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_fire)
         rsp_gap = rsp_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         if (rsp_valid_seen)
            rsp_gap--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // watchdog on cycles with no word moving on any channel
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         stall_count = 0;
      else
         stall_count++;
      if (stall_count >= STALL_LIMIT) begin
         $display("timeout after %0d idle cycles", stall_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do
         @(posedge clock);
      while (!csr_ch.ready);
      case (idx)
         CSR_BLOCK_LENGTH:     cfg_len    = value[LEN_W-1:0];
         CSR_ENERGY_THRESHOLD: cfg_thresh = value[ENERGY_W-1:0];
         CSR_FRAME_BYTES:      cfg_frame  = value[FRAME_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic queue_sample(input logic signed [SAMPLE_W-1:0] s, input logic l);
      sample_word_type w;
      w.sample = s;
      w.last   = l;
      samples_pending.push_back(w);
   endtask

   task automatic wait_quiet(input int pad);
      while (samples_pending.size() > 0 || req_busy || markers_due.size() > 0)
         @(posedge clock);
      repeat (pad) @(posedge clock);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] loud_sample();
      logic signed [SAMPLE_W-1:0] m;
      if ($urandom_range(0, 15) == 0)
         return SAMPLE_MIN;
      m = SAMPLE_W'($urandom_range(16384, 32767));
      return $urandom_range(0, 1) ? -m : m;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] quiet_sample();
      return SAMPLE_W'($urandom_range(0, 64) - 32);
   endfunction

   // bursts of loud and quiet samples with some noise and stray ends of stream
   task automatic fill_bursts(input int count, input int seg_max, input bit close_stream);
      int                         left;
      int                         seg;
      int                         roll;
      bit                         loud;
      logic signed [SAMPLE_W-1:0] s;
      left = count;
      while (left > 0) begin
         seg  = $urandom_range(1, seg_max);
         loud = $urandom_range(0, 1);
         for (int i = 0; i < seg && left > 0; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
               s = SAMPLE_W'($urandom());
            else
               s = loud ? loud_sample() : quiet_sample();
            queue_sample(s, roll == 99 || (close_stream && left == 1));
            left--;
         end
      end
   endtask

   initial begin
      int                  eff;
      logic [LEN_W-1:0]    blen;
      logic [ENERGY_W-1:0] thr;
      logic [FRAME_W-1:0]  frame;

      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.sample = '0;
      req_ch.last   = 1'b0;
      rsp_ch.ready  = 1'b0;
      csr_ch.valid  = 1'b0;
      csr_ch.index  = CSR_BLOCK_LENGTH;
      csr_ch.data   = '0;
      cfg_len    = BLOCK_LENGTH_RESET;
      cfg_thresh = ENERGY_THRESHOLD_RESET;
      cfg_frame  = FRAME_BYTES_RESET;
      clear_stream();
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed: turn on, equal energy, turn off, partial final block
      write_reg(CSR_BLOCK_LENGTH, 4);
      write_reg(CSR_ENERGY_THRESHOLD, 1000);
      write_reg(CSR_FRAME_BYTES, 3);
      queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample(SAMPLE_MIN, 1'b0);
      queue_sample(100, 1'b0);
      queue_sample(-1, 1'b0);
      queue_sample(10, 1'b0);
      queue_sample(30, 1'b0);
      queue_sample(0, 1'b0);
      queue_sample(0, 1'b0);
      queue_sample(0, 1'b0);
      queue_sample(1, 1'b0);
      queue_sample(-1, 1'b0);
      queue_sample(0, 1'b0);
      queue_sample(SAMPLE_MIN, 1'b0);
      queue_sample(0, 1'b0);
      queue_sample(0, 1'b1);
      repeat (4) queue_sample(20000, 1'b0);
      queue_sample(5, 1'b0);
      queue_sample(0, 1'b1);
      queue_sample(0, 1'b1);
      wait_quiet(SETTLE_CYCLES);

      // zero block length stands for the longest block
      write_reg(CSR_BLOCK_LENGTH, 0);
      write_reg(CSR_FRAME_BYTES, 255);
      queue_sample(SAMPLE_MIN, 1'b0);
      queue_sample(1, 1'b1);
      wait_quiet(SETTLE_CYCLES);

      // zero frame bytes
      write_reg(CSR_BLOCK_LENGTH, 2);
      write_reg(CSR_FRAME_BYTES, 0);
      queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample(0, 1'b0);
      queue_sample(0, 1'b0);
      wait_quiet(SETTLE_CYCLES);

      // block length shrunk below the position reached
      write_reg(CSR_BLOCK_LENGTH, 10);
      write_reg(CSR_FRAME_BYTES, 7);
      repeat (5) queue_sample(SAMPLE_MAX, 1'b0);
      wait_quiet(SETTLE_CYCLES);
      write_reg(CSR_BLOCK_LENGTH, 3);
      queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample(0, 1'b0);
      queue_sample(0, 1'b0);
      queue_sample(0, 1'b1);
      wait_quiet(SETTLE_CYCLES);

      // random phases over several settings
      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            3:       blen = 16'd65535;
            7:       blen = '0;
            default: blen = LEN_W'($urandom_range(1, 12));
         endcase
         eff = (blen == '0) ? 65536 : int'(blen);
         case (phase)
            5:       thr = '0;
            8:       thr = ENERGY_MAX;
            default: thr = ENERGY_W'((eff > 40 ? 40 : eff) *
                                     (longint'(1) << $urandom_range(20, 27)));
         endcase
         case (phase)
            1:       frame = 8'd1;
            2:       frame = 8'd255;
            6:       frame = '0;
            default: frame = FRAME_W'($urandom_range(0, 255));
         endcase
         req_idle_on = ($urandom_range(0, 2) != 0);
         rsp_idle_on = ($urandom_range(0, 2) != 0);
         write_reg(CSR_BLOCK_LENGTH, CSR_DATA_W'(blen));
         write_reg(CSR_ENERGY_THRESHOLD, CSR_DATA_W'(thr));
         write_reg(CSR_FRAME_BYTES, CSR_DATA_W'(frame));
         if (phase == 4)
            write_reg(CSR_UNUSED, CSR_DATA_W'({$urandom(), $urandom()}));
         if (eff > 40)
            fill_bursts(40, 40, 1'b1);
         else
            fill_bursts(55, 3 * eff, $urandom_range(0, 1));
         wait_quiet(SETTLE_CYCLES);
      end

      // long receiver stall with one marker every two words
      write_reg(CSR_BLOCK_LENGTH, 1);
      write_reg(CSR_ENERGY_THRESHOLD, 1 << 20);
      write_reg(CSR_FRAME_BYTES, 4);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b1;
      rsp_hold_left = HOLD_CYCLES;
      for (int i = 0; i < 120; i++)
         queue_sample((i % 2 == 0) ? loud_sample() : quiet_sample(), i == 119);
      wait_quiet(TAIL_CYCLES);

      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
